### hw/rtl/lnf_pkg.sv
// Shared types, constants and fp16/fp32 conversion functions for the layer norm block.
package lnf_pkg;

  localparam int unsigned RowMaxDef = 1024;

  localparam logic [31:0] EpsReset = 32'h3727C5AC;
  localparam logic [31:0] FpOne    = 32'h3F800000;
  localparam logic [31:0] FpZero   = 32'h00000000;
  localparam logic [31:0] FpNan    = 32'h7FC00000;
  localparam logic [15:0] HalfNan  = 16'h7E00;

  localparam logic [1:0] CfgEps   = 2'd0;
  localparam logic [1:0] CfgGamma = 2'd1;
  localparam logic [1:0] CfgBeta  = 2'd2;

  typedef enum logic [2:0] {
    FpAdd,
    FpSub,
    FpMul,
    FpDiv,
    FpSqrt,
    FpI2f
  } fp_op_e;

  typedef struct packed {
    logic        start;
    fp_op_e      op;
    logic [31:0] a;
    logic [31:0] b;
  } fp_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] res;
  } fp_rsp_t;

  function automatic logic [31:0] half_to_single(input logic [15:0] h);
    logic [10:0] mm;
    logic [7:0]  ex;
    logic [7:0]  nex;
    mm  = {1'b0, h[9:0]};
    ex  = 8'd113;
    nex = {3'b0, h[14:10]} + 8'd112;
    if (h[14:10] == 5'h1f) begin
      return {h[15], 8'hff, h[9:0], 13'b0};
    end
    if (h[14:10] == 5'h00) begin
      if (h[9:0] == 10'd0) begin
        return {h[15], 31'b0};
      end
      for (int i = 0; i < 10; i++) begin
        if (!mm[10]) begin
          mm = {mm[9:0], 1'b0};
          ex = ex - 8'd1;
        end
      end
      return {h[15], ex, mm[9:0], 13'b0};
    end
    return {h[15], nex, h[9:0], 13'b0};
  endfunction

  function automatic logic [15:0] single_to_half(input logic [31:0] f);
    logic        sgn;
    logic [7:0]  e;
    logic [22:0] m;
    logic [7:0]  te;
    logic [14:0] h15;
    logic [12:0] rem;
    logic [23:0] m24;
    logic [4:0]  sh;
    logic [23:0] hs;
    logic [23:0] rs;
    logic [23:0] hf;
    sgn = f[31];
    e   = f[30:23];
    m   = f[22:0];
    te  = e - 8'd112;
    h15 = {te[4:0], m[22:13]};
    rem = m[12:0];
    m24 = {1'b1, m};
    sh  = 5'(8'd126 - e);
    hs  = m24 >> sh;
    rs  = m24 & ((24'd1 << sh) - 24'd1);
    hf  = 24'd1 << (sh - 5'd1);
    if (e == 8'hff) begin
      return (m != 23'd0) ? HalfNan : {sgn, 15'h7c00};
    end
    if (e == 8'h00) begin
      return {sgn, 15'b0};
    end
    if (e > 8'd142) begin
      return {sgn, 15'h7c00};
    end
    if (e >= 8'd113) begin
      if (rem > 13'h1000 || (rem == 13'h1000 && h15[0])) begin
        h15 = h15 + 15'd1;
      end
      return {sgn, h15};
    end
    if (e < 8'd102) begin
      return {sgn, 15'b0};
    end
    if (rs > hf || (rs == hf && hs[0])) begin
      hs = hs + 24'd1;
    end
    return {sgn, hs[14:0]};
  endfunction

endpackage

### hw/rtl/lnf_fpu.sv
// Multi-cycle fp32 unit: add, subtract, multiply, divide, square root and integer convert.
module lnf_fpu import lnf_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  fp_req_t req_i,
  output fp_rsp_t rsp_o
);

  typedef enum logic [2:0] {
    StIdle,
    StPrenorm,
    StDivide,
    StRoot,
    StNorm,
    StDenorm,
    StRound
  } state_e;

  state_e             state_q;
  fp_op_e             op_q;
  logic               sign_q;
  logic [23:0]        ma_q, mb_q;
  logic signed [12:0] ea_q, eb_q, exp_q;
  logic [63:0]        mant_q;
  logic               stk_q;
  logic [4:0]         cnt_q;
  logic [26:0]        quo_q;
  logic [28:0]        rem_q;
  logic [51:0]        rad_q;
  logic [31:0]        res_q;
  logic               done_q;

  logic               a_sgn, b_sgn, b_eff;
  logic [7:0]         a_exp, b_exp;
  logic [23:0]        a_man, b_man;
  logic signed [12:0] a_lsb, b_lsb;
  logic               a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;

  logic               swap;
  logic [23:0]        big_m, sml_m;
  logic signed [12:0] big_e, sml_e, diff;
  logic               big_s;
  logic [63:0]        big_w, sml_w, sml_sh, sum_w;
  logic               sml_stk;
  logic [47:0]        prod;

  logic               dv_ge;
  logic [24:0]        dv_rem;
  logic [26:0]        dv_quo;
  logic [28:0]        rt_cur, rt_trial, rt_rem;
  logic               rt_ge;
  logic [26:0]        rt_root;
  logic signed [12:0] sq_eo;

  logic [24:0]        rnd_sig;
  logic               rnd_up;
  logic [23:0]        rnd_man;
  logic signed [12:0] rnd_exp;

  always_comb begin
    a_sgn  = req_i.a[31];
    b_sgn  = req_i.b[31];
    b_eff  = b_sgn ^ (req_i.op == FpSub);
    a_exp  = req_i.a[30:23];
    b_exp  = req_i.b[30:23];
    a_man  = {a_exp != 8'd0, req_i.a[22:0]};
    b_man  = {b_exp != 8'd0, req_i.b[22:0]};
    a_lsb  = (a_exp == 8'd0) ? -13'sd149 : $signed({5'b0, a_exp}) - 13'sd150;
    b_lsb  = (b_exp == 8'd0) ? -13'sd149 : $signed({5'b0, b_exp}) - 13'sd150;
    a_nan  = (a_exp == 8'hff) && (req_i.a[22:0] != 23'd0);
    b_nan  = (b_exp == 8'hff) && (req_i.b[22:0] != 23'd0);
    a_inf  = (a_exp == 8'hff) && (req_i.a[22:0] == 23'd0);
    b_inf  = (b_exp == 8'hff) && (req_i.b[22:0] == 23'd0);
    a_zero = (req_i.a[30:0] == 31'd0);
    b_zero = (req_i.b[30:0] == 31'd0);

    swap   = (b_lsb > a_lsb) || ((b_lsb == a_lsb) && (b_man > a_man));
    big_m  = swap ? b_man : a_man;
    sml_m  = swap ? a_man : b_man;
    big_e  = swap ? b_lsb : a_lsb;
    sml_e  = swap ? a_lsb : b_lsb;
    big_s  = swap ? b_eff : a_sgn;
    diff   = big_e - sml_e;
    big_w  = {4'b0, big_m, 36'b0};
    sml_w  = {4'b0, sml_m, 36'b0};
    if (diff > 13'sd63) begin
      sml_sh  = 64'd0;
      sml_stk = |sml_w;
    end else begin
      sml_sh  = sml_w >> diff[5:0];
      sml_stk = |(sml_w & ~({64{1'b1}} << diff[5:0]));
    end
    sml_sh[0] = sml_sh[0] | sml_stk;
    sum_w  = (a_sgn != b_eff) ? big_w - sml_sh : big_w + sml_sh;
    prod   = a_man * b_man;

    dv_ge  = rem_q[24:0] >= {1'b0, mb_q};
    dv_rem = dv_ge ? rem_q[24:0] - {1'b0, mb_q} : rem_q[24:0];
    dv_quo = {quo_q[25:0], dv_ge};

    rt_cur   = {rem_q[26:0], rad_q[51:50]};
    rt_trial = {1'b0, quo_q[25:0], 2'b01};
    rt_ge    = rt_cur >= rt_trial;
    rt_rem   = rt_ge ? rt_cur - rt_trial : rt_cur;
    rt_root  = {quo_q[25:0], rt_ge};
    sq_eo    = ea_q[0] ? ea_q - 13'sd1 : ea_q;

    rnd_up  = mant_q[39] && ((|mant_q[38:0]) || stk_q || mant_q[40]);
    rnd_sig = {1'b0, mant_q[63:40]} + {24'd0, rnd_up};
    rnd_man = rnd_sig[24] ? rnd_sig[24:1] : rnd_sig[23:0];
    rnd_exp = exp_q + (rnd_sig[24] ? 13'sd1 : 13'sd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        StIdle: begin
          if (req_i.start) begin
            op_q  <= req_i.op;
            stk_q <= 1'b0;
            case (req_i.op)
              FpAdd, FpSub: begin
                if (a_nan || b_nan || (a_inf && b_inf && (a_sgn != b_eff))) begin
                  res_q  <= FpNan;
                  done_q <= 1'b1;
                end else if (a_inf) begin
                  res_q  <= {a_sgn, 8'hff, 23'd0};
                  done_q <= 1'b1;
                end else if (b_inf) begin
                  res_q  <= {b_eff, 8'hff, 23'd0};
                  done_q <= 1'b1;
                end else if (sum_w == 64'd0) begin
                  res_q  <= {a_sgn & b_eff, 31'd0};
                  done_q <= 1'b1;
                end else begin
                  sign_q  <= big_s;
                  mant_q  <= sum_w;
                  exp_q   <= big_e - 13'sd36;
                  state_q <= StNorm;
                end
              end
              FpMul: begin
                if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) begin
                  res_q  <= FpNan;
                  done_q <= 1'b1;
                end else if (a_inf || b_inf) begin
                  res_q  <= {a_sgn ^ b_sgn, 8'hff, 23'd0};
                  done_q <= 1'b1;
                end else if (a_zero || b_zero) begin
                  res_q  <= {a_sgn ^ b_sgn, 31'd0};
                  done_q <= 1'b1;
                end else begin
                  sign_q  <= a_sgn ^ b_sgn;
                  mant_q  <= {16'd0, prod};
                  exp_q   <= a_lsb + b_lsb;
                  state_q <= StNorm;
                end
              end
              FpDiv: begin
                if (a_nan || b_nan || (a_zero && b_zero) || (a_inf && b_inf)) begin
                  res_q  <= FpNan;
                  done_q <= 1'b1;
                end else if (a_inf || b_zero) begin
                  res_q  <= {a_sgn ^ b_sgn, 8'hff, 23'd0};
                  done_q <= 1'b1;
                end else if (a_zero || b_inf) begin
                  res_q  <= {a_sgn ^ b_sgn, 31'd0};
                  done_q <= 1'b1;
                end else begin
                  sign_q  <= a_sgn ^ b_sgn;
                  ma_q    <= a_man;
                  mb_q    <= b_man;
                  ea_q    <= a_lsb;
                  eb_q    <= b_lsb;
                  state_q <= StPrenorm;
                end
              end
              FpSqrt: begin
                if (a_zero) begin
                  res_q  <= req_i.a;
                  done_q <= 1'b1;
                end else if (a_sgn) begin
                  res_q  <= FpNan;
                  done_q <= 1'b1;
                end else if (a_exp == 8'hff) begin
                  res_q  <= req_i.a;
                  done_q <= 1'b1;
                end else begin
                  sign_q  <= 1'b0;
                  ma_q    <= a_man;
                  mb_q    <= 24'h800000;
                  ea_q    <= a_lsb;
                  eb_q    <= 13'sd0;
                  state_q <= StPrenorm;
                end
              end
              FpI2f: begin
                if (req_i.a == 32'd0) begin
                  res_q  <= FpZero;
                  done_q <= 1'b1;
                end else begin
                  sign_q  <= 1'b0;
                  mant_q  <= {32'd0, req_i.a};
                  exp_q   <= 13'sd0;
                  state_q <= StNorm;
                end
              end
              default: begin
                res_q  <= FpNan;
                done_q <= 1'b1;
              end
            endcase
          end
        end
        StPrenorm: begin
          if (ma_q[23] && mb_q[23]) begin
            quo_q <= 27'd0;
            if (op_q == FpDiv) begin
              rem_q   <= {5'b0, ma_q};
              exp_q   <= ea_q - eb_q - 13'sd27;
              cnt_q   <= 5'd26;
              state_q <= StDivide;
            end else begin
              rem_q   <= 29'd0;
              rad_q   <= ea_q[0] ? {1'b0, ma_q, 1'b0, 26'd0} : {2'b0, ma_q, 26'd0};
              exp_q   <= ((sq_eo - 13'sd26) >>> 1) - 13'sd1;
              cnt_q   <= 5'd25;
              state_q <= StRoot;
            end
          end else begin
            if (!ma_q[23]) begin
              ma_q <= {ma_q[22:0], 1'b0};
              ea_q <= ea_q - 13'sd1;
            end
            if (!mb_q[23]) begin
              mb_q <= {mb_q[22:0], 1'b0};
              eb_q <= eb_q - 13'sd1;
            end
          end
        end
        StDivide: begin
          quo_q <= dv_quo;
          rem_q <= {4'b0, dv_rem[23:0], 1'b0};
          cnt_q <= cnt_q - 5'd1;
          if (cnt_q == 5'd0) begin
            mant_q  <= {36'd0, dv_quo, |dv_rem};
            state_q <= StNorm;
          end
        end
        StRoot: begin
          quo_q <= rt_root;
          rem_q <= rt_rem;
          rad_q <= {rad_q[49:0], 2'b00};
          cnt_q <= cnt_q - 5'd1;
          if (cnt_q == 5'd0) begin
            mant_q  <= {37'd0, rt_root[25:0], |rt_rem};
            state_q <= StNorm;
          end
        end
        StNorm: begin
          if (mant_q[63]) begin
            exp_q   <= exp_q + 13'sd190;
            state_q <= StDenorm;
          end else if (mant_q[63:56] == 8'd0) begin
            mant_q <= {mant_q[55:0], 8'd0};
            exp_q  <= exp_q - 13'sd8;
          end else begin
            mant_q <= {mant_q[62:0], 1'b0};
            exp_q  <= exp_q - 13'sd1;
          end
        end
        StDenorm: begin
          if (exp_q > 13'sd0) begin
            state_q <= StRound;
          end else if (exp_q < -13'sd40) begin
            stk_q  <= stk_q | (|mant_q);
            mant_q <= 64'd0;
            exp_q  <= 13'sd1;
          end else begin
            stk_q  <= stk_q | mant_q[0];
            mant_q <= {1'b0, mant_q[63:1]};
            exp_q  <= exp_q + 13'sd1;
          end
        end
        StRound: begin
          if (rnd_exp >= 13'sd255) begin
            res_q <= {sign_q, 8'hff, 23'd0};
          end else begin
            res_q <= {sign_q, rnd_man[23] ? rnd_exp[7:0] : 8'd0, rnd_man[22:0]};
          end
          done_q  <= 1'b1;
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = res_q;

endmodule

### hw/rtl/layer_norm_fp16_top.sv
// Layer normalization of fp16 rows with fp32 statistics: row buffer, sequencer and output stage.
//
// Input channel (in_valid_i/in_ready_o) carries one command per transfer. A load
// (cmd_i = 0) stores sample_i in the row buffer and folds it into the fp32 sum and
// sum of squares; the load with row_end_i set closes the row and computes mean and
// 1/sqrt(var + eps). An apply (cmd_i = 1) normalizes the next stored sample with
// scale_i and shift_i and emits one fp16 result on the output channel, only when the
// row is closed and unread samples remain. A load beyond ROW_MAX samples is not
// stored and marks the row as overflowed. A stored load takes 3 fp32 operations;
// a closing load adds a convert, three divides, a square root and three more
// operations. An apply takes one buffer read and up to four fp32 operations. The
// single shared fp32 unit runs one item at a time; in_ready_o is high only when idle.
// Configuration (cfg_valid_i/cfg_ready_o) writes eps and the gamma/beta enables
// and is always ready; write it only while no item is in flight.
// Reset clears the statistics, counters and flags and loads the default eps; the
// row buffer is not cleared. A result waits in the output register while the
// receiver stalls; the next item is still accepted, and an apply that finishes
// before the register drains holds until its result can be written.
module layer_norm_fp16_top import lnf_pkg::*; #(
  parameter int unsigned ROW_MAX = RowMaxDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        cmd_i,
  input  logic [15:0] sample_i,
  input  logic [15:0] scale_i,
  input  logic [15:0] shift_i,
  input  logic        row_end_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] result_o,
  output logic        final_res_o,
  output logic        overflowed_o
);

  localparam int unsigned AW = (ROW_MAX > 1) ? $clog2(ROW_MAX) : 1;
  localparam int unsigned CW = $clog2(ROW_MAX + 1);
  localparam logic [CW-1:0] CntMax = CW'(ROW_MAX);

  typedef enum logic [4:0] {
    StIdle,
    StLdSq,
    StLdSum,
    StLdSqs,
    StCvt,
    StMean,
    StMsq,
    StVar,
    StVsub,
    StEps,
    StRoot,
    StInv,
    StRead,
    StApSub,
    StApMul,
    StApGam,
    StApBeta,
    StEmit
  } state_e;

  state_e        state_q;
  logic          busy_q;
  logic [31:0]   sum_q, sq_q, mean_q, inv_q;
  logic [31:0]   x_q, t_q, k_q;
  logic [CW-1:0] cnt_q, idx_q;
  logic          drop_q, ready_q, last_q;
  logic [31:0]   eps_q;
  logic          use_g_q, use_b_q;
  logic [15:0]   scale_q, shift_q;
  logic          out_valid_q;
  logic [15:0]   result_q;
  logic          final_q, ovf_q;

  logic [15:0]   row_mem [ROW_MAX];
  logic [15:0]   rd_data_q;

  fp_req_t       fp_req;
  fp_rsp_t       fp_rsp;
  logic          op_state;

  logic          in_xfer, ld_xfer, ap_xfer;
  logic [CW-1:0] cnt_eff, idx_nxt;
  logic          mem_we;

  assign in_ready_o  = (state_q == StIdle);
  assign cfg_ready_o = 1'b1;
  assign in_xfer     = in_valid_i && in_ready_o;
  assign ld_xfer     = in_xfer && !cmd_i;
  assign ap_xfer     = in_xfer && cmd_i;
  assign cnt_eff     = ready_q ? '0 : cnt_q;
  assign mem_we      = ld_xfer && (cnt_eff < CntMax);
  assign idx_nxt     = idx_q + CW'(1);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      row_mem[cnt_eff[AW-1:0]] <= sample_i;
    end
    if (ap_xfer) begin
      rd_data_q <= row_mem[idx_q[AW-1:0]];
    end
  end

  always_comb begin
    op_state = 1'b1;
    fp_req.op = FpAdd;
    fp_req.a  = x_q;
    fp_req.b  = t_q;
    case (state_q)
      StLdSq:   begin fp_req.op = FpMul;  fp_req.a = x_q;    fp_req.b = x_q;    end
      StLdSum:  begin fp_req.op = FpAdd;  fp_req.a = sum_q;  fp_req.b = x_q;    end
      StLdSqs:  begin fp_req.op = FpAdd;  fp_req.a = sq_q;   fp_req.b = t_q;    end
      StCvt: begin
        fp_req.op = FpI2f;
        fp_req.a  = {{(32-CW){1'b0}}, cnt_q};
        fp_req.b  = FpZero;
      end
      StMean:   begin fp_req.op = FpDiv;  fp_req.a = sum_q;  fp_req.b = k_q;    end
      StMsq:    begin fp_req.op = FpMul;  fp_req.a = mean_q; fp_req.b = mean_q; end
      StVar:    begin fp_req.op = FpDiv;  fp_req.a = sq_q;   fp_req.b = k_q;    end
      StVsub:   begin fp_req.op = FpSub;  fp_req.a = x_q;    fp_req.b = t_q;    end
      StEps:    begin fp_req.op = FpAdd;  fp_req.a = x_q;    fp_req.b = eps_q;  end
      StRoot:   begin fp_req.op = FpSqrt; fp_req.a = x_q;    fp_req.b = FpZero; end
      StInv:    begin fp_req.op = FpDiv;  fp_req.a = FpOne;  fp_req.b = x_q;    end
      StApSub:  begin fp_req.op = FpSub;  fp_req.a = x_q;    fp_req.b = mean_q; end
      StApMul:  begin fp_req.op = FpMul;  fp_req.a = x_q;    fp_req.b = inv_q;  end
      StApGam: begin
        fp_req.op = FpMul;
        fp_req.a  = x_q;
        fp_req.b  = half_to_single(scale_q);
      end
      StApBeta: begin
        fp_req.op = FpAdd;
        fp_req.a  = x_q;
        fp_req.b  = half_to_single(shift_q);
      end
      default:  op_state = 1'b0;
    endcase
    fp_req.start = op_state && !busy_q;
  end

  lnf_fpu u_fpu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (fp_req),
    .rsp_o  (fp_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      busy_q      <= 1'b0;
      sum_q       <= FpZero;
      sq_q        <= FpZero;
      mean_q      <= FpZero;
      inv_q       <= FpZero;
      cnt_q       <= '0;
      idx_q       <= '0;
      drop_q      <= 1'b0;
      ready_q     <= 1'b0;
      last_q      <= 1'b0;
      eps_q       <= EpsReset;
      use_g_q     <= 1'b1;
      use_b_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CfgEps:   eps_q   <= cfg_data_i;
          CfgGamma: use_g_q <= cfg_data_i[0];
          CfgBeta:  use_b_q <= cfg_data_i[0];
          default:  ;
        endcase
      end

      if (out_valid_q && out_ready_i && (state_q != StEmit)) begin
        out_valid_q <= 1'b0;
      end

      if (fp_req.start) begin
        busy_q <= 1'b1;
      end
      if (fp_rsp.done) begin
        busy_q <= 1'b0;
      end

      case (state_q)
        StIdle: begin
          if (ld_xfer) begin
            last_q <= row_end_i;
            if (ready_q) begin
              ready_q <= 1'b0;
              idx_q   <= '0;
              drop_q  <= 1'b0;
              sum_q   <= FpZero;
              sq_q    <= FpZero;
            end
            if (cnt_eff < CntMax) begin
              cnt_q   <= cnt_eff + CW'(1);
              x_q     <= half_to_single(sample_i);
              state_q <= StLdSq;
            end else begin
              cnt_q   <= cnt_eff;
              drop_q  <= 1'b1;
              state_q <= row_end_i ? StCvt : StIdle;
            end
          end else if (ap_xfer) begin
            scale_q <= scale_i;
            shift_q <= shift_i;
            if (ready_q && (idx_q < cnt_q)) begin
              state_q <= StRead;
            end
          end
        end
        StLdSq: if (fp_rsp.done) begin t_q <= fp_rsp.res; state_q <= StLdSum; end
        StLdSum: if (fp_rsp.done) begin sum_q <= fp_rsp.res; state_q <= StLdSqs; end
        StLdSqs: begin
          if (fp_rsp.done) begin
            sq_q    <= fp_rsp.res;
            state_q <= last_q ? StCvt : StIdle;
          end
        end
        StCvt:  if (fp_rsp.done) begin k_q <= fp_rsp.res; state_q <= StMean; end
        StMean: if (fp_rsp.done) begin mean_q <= fp_rsp.res; state_q <= StMsq; end
        StMsq:  if (fp_rsp.done) begin t_q <= fp_rsp.res; state_q <= StVar; end
        StVar:  if (fp_rsp.done) begin x_q <= fp_rsp.res; state_q <= StVsub; end
        StVsub: if (fp_rsp.done) begin x_q <= fp_rsp.res; state_q <= StEps; end
        StEps:  if (fp_rsp.done) begin x_q <= fp_rsp.res; state_q <= StRoot; end
        StRoot: if (fp_rsp.done) begin x_q <= fp_rsp.res; state_q <= StInv; end
        StInv: begin
          if (fp_rsp.done) begin
            inv_q   <= fp_rsp.res;
            ready_q <= 1'b1;
            idx_q   <= '0;
            sum_q   <= FpZero;
            sq_q    <= FpZero;
            state_q <= StIdle;
          end
        end
        StRead: begin
          x_q     <= half_to_single(rd_data_q);
          state_q <= StApSub;
        end
        StApSub: if (fp_rsp.done) begin x_q <= fp_rsp.res; state_q <= StApMul; end
        StApMul: begin
          if (fp_rsp.done) begin
            x_q     <= fp_rsp.res;
            state_q <= use_g_q ? StApGam : (use_b_q ? StApBeta : StEmit);
          end
        end
        StApGam: begin
          if (fp_rsp.done) begin
            x_q     <= fp_rsp.res;
            state_q <= use_b_q ? StApBeta : StEmit;
          end
        end
        StApBeta: if (fp_rsp.done) begin x_q <= fp_rsp.res; state_q <= StEmit; end
        StEmit: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            result_q    <= single_to_half(x_q);
            final_q     <= (idx_nxt == cnt_q);
            ovf_q       <= drop_q;
            idx_q       <= idx_nxt;
            state_q     <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign result_o     = result_q;
  assign final_res_o  = final_q;
  assign overflowed_o = ovf_q;

endmodule
